// ===== design/fkhp_pkg.sv =====
`timescale 1ns / 1ps

package fkhp_pkg;

  localparam int OffsetWidth = 7;

  typedef logic [OffsetWidth-1:0] offset_t;

  localparam offset_t OFFSET_MAX   = offset_t'(127);
  localparam offset_t POS_ETYPE_HI = offset_t'(12);
  localparam offset_t POS_ETYPE_LO = offset_t'(13);
  localparam offset_t ETH_HDR_LEN  = offset_t'(14);
  localparam offset_t POS_V4_PROTO = offset_t'(23);
  localparam offset_t POS_V4_SRC   = offset_t'(26);
  localparam offset_t POS_V4_DST   = offset_t'(30);
  localparam offset_t POS_V4_L4    = offset_t'(34);
  localparam offset_t POS_V6_NEXT  = offset_t'(20);
  localparam offset_t POS_V6_SRC   = offset_t'(22);
  localparam offset_t POS_V6_SRCLO = offset_t'(30);
  localparam offset_t POS_V6_DST   = offset_t'(38);
  localparam offset_t POS_V6_DSTLO = offset_t'(46);
  localparam offset_t POS_V6_L4    = offset_t'(54);
  localparam offset_t TCP_HDR_LEN  = offset_t'(20);
  localparam offset_t UDP_HDR_LEN  = offset_t'(8);
  localparam offset_t PORT_SRC_END = offset_t'(2);
  localparam offset_t PORT_DST_END = offset_t'(4);

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam logic [3:0]  IHL_MIN    = 4'd5;

  localparam logic FAMILY_IPV4 = 1'b0;
  localparam logic FAMILY_IPV6 = 1'b1;

  typedef enum logic [1:0] {
    VERDICT_PARSED = 2'd0,
    VERDICT_PASS   = 2'd1,
    VERDICT_DROP   = 2'd2
  } verdict_t;

  typedef struct packed {
    offset_t     offset;
    logic [15:0] ether_type;
    logic [3:0]  header_words;
    logic [7:0]  next_protocol;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
    logic [15:0] sport;
    logic [15:0] dport;
  } key_t;

  typedef struct packed {
    verdict_t    verdict;
    logic        family;
    logic [7:0]  protocol;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
    logic [15:0] sport;
    logic [15:0] dport;
  } result_t;

endpackage

// ===== design/flow_key_header_parser_unit.sv =====
`timescale 1ns / 1ps
// the result request is registered in the output skid buffer after the last byte of a frame is taken
// throughput: one frame byte per cycle while s_tready is high; a result follows each last byte
// the byte path only stalls while two results wait at the output
// reset (rst, synchronous) clears all captured fields, the byte count and the valid flags of both result slots

module flow_key_header_parser_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // data_byte
  input  logic         s_tlast,   // last_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  // protocol, src_addr_hi, src_addr_lo, dst_addr_hi, dst_addr_lo, sport, dport
  output logic [295:0] m_tdata,
  output logic [2:0]   m_tuser    // verdict, family
);
  import fkhp_pkg::*;

  logic    accept;
  logic    push;
  key_t    key_next;
  result_t result;
  result_t out_data;

  assign accept = s_tvalid && s_tready;
  assign push = accept && s_tlast;

  fkhp_capture u_capture (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (s_tdata),
    .last_byte (s_tlast),
    .key_next  (key_next)
  );

  fkhp_verdict u_verdict (
    .key    (key_next),
    .result (result)
  );

  fkhp_out_skid u_out (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (result),
    .push_ready (s_tready),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (out_data)
  );

  assign m_tdata = {out_data.dport, out_data.sport, out_data.dst_lo, out_data.dst_hi,
                    out_data.src_lo, out_data.src_hi, out_data.protocol};
  assign m_tuser = {out_data.family, out_data.verdict};

endmodule

// ===== design/fkhp_capture.sv =====
`timescale 1ns / 1ps

module fkhp_capture (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    data_byte,
  input  logic          last_byte,
  output fkhp_pkg::key_t key_next
);
  import fkhp_pkg::*;

  key_t    key;
  offset_t pos;
  offset_t l4_start;
  offset_t rel;

  assign pos = key.offset;
  assign l4_start = ETH_HDR_LEN + offset_t'({key.header_words, 2'b00});
  assign rel = pos - l4_start;

  always_comb begin
    key_next = key;
    if (key.offset != OFFSET_MAX) begin
      key_next.offset = key.offset + offset_t'(1);
    end
    if (pos == POS_ETYPE_HI) begin
      key_next.ether_type = {data_byte, 8'h00};
    end else if (pos == POS_ETYPE_LO) begin
      key_next.ether_type = {key.ether_type[15:8], data_byte};
    end else if (pos >= ETH_HDR_LEN) begin
      if (key.ether_type == ETYPE_IPV4) begin
        if (pos == ETH_HDR_LEN) begin
          key_next.header_words = data_byte[3:0];
        end else if (pos == POS_V4_PROTO) begin
          key_next.next_protocol = data_byte;
        end else if (pos >= POS_V4_SRC && pos < POS_V4_DST) begin
          key_next.src_lo = {32'h0, key.src_lo[23:0], data_byte};
        end else if (pos >= POS_V4_DST && pos < POS_V4_L4) begin
          key_next.dst_lo = {32'h0, key.dst_lo[23:0], data_byte};
        end else if (pos >= POS_V4_L4 && key.header_words >= IHL_MIN && pos >= l4_start) begin
          if (rel < PORT_SRC_END) begin
            key_next.sport = {key.sport[7:0], data_byte};
          end else if (rel < PORT_DST_END) begin
            key_next.dport = {key.dport[7:0], data_byte};
          end
        end
      end else if (key.ether_type == ETYPE_IPV6) begin
        if (pos == POS_V6_NEXT) begin
          key_next.next_protocol = data_byte;
        end else if (pos >= POS_V6_SRC && pos < POS_V6_SRCLO) begin
          key_next.src_hi = {key.src_hi[55:0], data_byte};
        end else if (pos >= POS_V6_SRCLO && pos < POS_V6_DST) begin
          key_next.src_lo = {key.src_lo[55:0], data_byte};
        end else if (pos >= POS_V6_DST && pos < POS_V6_DSTLO) begin
          key_next.dst_hi = {key.dst_hi[55:0], data_byte};
        end else if (pos >= POS_V6_DSTLO && pos < POS_V6_L4) begin
          key_next.dst_lo = {key.dst_lo[55:0], data_byte};
        end else if (pos >= POS_V6_L4) begin
          if ((pos - POS_V6_L4) < PORT_SRC_END) begin
            key_next.sport = {key.sport[7:0], data_byte};
          end else if ((pos - POS_V6_L4) < PORT_DST_END) begin
            key_next.dport = {key.dport[7:0], data_byte};
          end
        end
      end
    end
  end

  // state clears after the last byte of each frame
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (accept) begin
      if (last_byte) begin
        key <= '0;
      end else begin
        key <= key_next;
      end
    end
  end

endmodule

// ===== design/fkhp_verdict.sv =====
`timescale 1ns / 1ps

module fkhp_verdict (
  input  fkhp_pkg::key_t    key,
  output fkhp_pkg::result_t result
);
  import fkhp_pkg::*;

  offset_t  len;
  offset_t  need;
  offset_t  v4_start;
  logic     is_l4;
  logic     fam;
  verdict_t verdict;

  assign len = key.offset;
  assign is_l4 = (key.next_protocol == PROTO_TCP) || (key.next_protocol == PROTO_UDP);
  assign need = (key.next_protocol == PROTO_TCP) ? TCP_HDR_LEN : UDP_HDR_LEN;
  assign v4_start = ETH_HDR_LEN + offset_t'({key.header_words, 2'b00});

  always_comb begin
    fam = FAMILY_IPV4;
    priority if (len < ETH_HDR_LEN) begin
      verdict = VERDICT_DROP;
    end else if (key.ether_type == ETYPE_IPV4) begin
      if (len < POS_V4_L4) begin
        verdict = VERDICT_DROP;
      end else if (!is_l4) begin
        verdict = VERDICT_PASS;
      end else if (key.header_words < IHL_MIN) begin
        verdict = VERDICT_DROP;
      end else if (len < v4_start + need) begin
        verdict = VERDICT_DROP;
      end else begin
        verdict = VERDICT_PARSED;
      end
    end else if (key.ether_type == ETYPE_IPV6) begin
      fam = FAMILY_IPV6;
      if (len < POS_V6_L4) begin
        verdict = VERDICT_DROP;
      end else if (!is_l4) begin
        verdict = VERDICT_PASS;
      end else if (len < POS_V6_L4 + need) begin
        verdict = VERDICT_DROP;
      end else begin
        verdict = VERDICT_PARSED;
      end
    end else begin
      verdict = VERDICT_PASS;
    end
  end

  always_comb begin
    result = '0;
    result.verdict = verdict;
    if (verdict == VERDICT_PARSED) begin
      result.family   = fam;
      result.protocol = key.next_protocol;
      result.src_hi   = key.src_hi;
      result.src_lo   = key.src_lo;
      result.dst_hi   = key.dst_hi;
      result.dst_lo   = key.dst_lo;
      result.sport    = key.sport;
      result.dport    = key.dport;
    end
  end

endmodule

// ===== design/fkhp_out_skid.sv =====
`timescale 1ns / 1ps

module fkhp_out_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  fkhp_pkg::result_t push_data,
  output logic              push_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output fkhp_pkg::result_t out_data
);
  import fkhp_pkg::*;

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign push_ready = !skid_valid;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= push;
        end
      end else if (push) begin
        if (out_valid) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      out_data <= skid_data;
    end else if (push && (pop || !out_valid)) begin
      out_data <= push_data;
    end
    if (push && out_valid && !pop) begin
      skid_data <= push_data;
    end
  end

endmodule

// ===== design/fkhp_checker.sv =====
`timescale 1ns / 1ps

module fkhp_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         s_tlast,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [295:0] m_tdata,
  input logic [2:0]   m_tuser
);
  import fkhp_pkg::*;

  a_no_bad_verdict: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser[1:0] != 2'd3)
    else $error("reserved verdict code");

  a_unparsed_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1:0] != VERDICT_PARSED) |-> (m_tdata == '0 && !m_tuser[2]))
    else $error("pass or drop result carries key data");

  a_parsed_proto: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1:0] == VERDICT_PARSED) |->
      (m_tdata[7:0] == PROTO_TCP || m_tdata[7:0] == PROTO_UDP))
    else $error("parsed result with non transport protocol");

  a_result_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
    else $error("result without a last byte");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result request changed");

endmodule

bind flow_key_header_parser_unit fkhp_checker u_fkhp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
